@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the scan core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ETS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define ETS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/ets_pkg.sv @@
// Package: shared types and constants of the expression token scanner
`default_nettype none
package ets_pkg;
   localparam int PositionBits = 16;
   localparam int MaxResults   = 4;

   typedef enum logic [3:0] {
      S_IDLE = 4'd0, S_OP = 4'd1, S_LINE = 4'd2, S_BLOCK = 4'd3, S_BLOCK_STAR = 4'd4,
      S_ZERO = 4'd5, S_NUM = 4'd6, S_NUM_DOT = 4'd7, S_FRAC = 4'd8, S_IDENT = 4'd9
   } scan_state_type;

   typedef enum logic [1:0] {B_DEC = 2'd0, B_OCT = 2'd1, B_HEX = 2'd2, B_BIN = 2'd3} base_type;

   localparam logic [4:0] K_DOT = 5'd6, K_BANG = 5'd12, K_BANG_EQ = 5'd13, K_EQ_EQ = 5'd14,
      K_LESS = 5'd15, K_LESS_EQ = 5'd16, K_GREATER = 5'd17, K_GREATER_EQ = 5'd18,
      K_BAND = 5'd19, K_LAND = 5'd20, K_BOR = 5'd21, K_LOR = 5'd22, K_SLASH = 5'd23,
      K_NUMBER = 5'd24, K_IDENT = 5'd25, K_TRUE = 5'd26, K_FALSE = 5'd27, K_END = 5'd28;

   localparam logic [2:0] E_NONE = 3'd0, E_UNEXPECTED = 3'd1, E_OPEN_COMMENT = 3'd2,
      E_ADJ_SEP = 3'd3, E_INVALID_NUM = 3'd4, E_FRACTION = 3'd5;

   // One result beat
   typedef struct packed {
      logic        is_token;
      logic [4:0]  token_kind;
      logic [2:0]  error_code;
      logic [15:0] lexeme_start;
      logic [15:0] lexeme_length;
      logic [15:0] line_number;
      logic [30:0] literal_value;
   } result_type;

   // Up to four results of one input byte
   typedef struct packed {
      logic [2:0]                  count;
      result_type [MaxResults-1:0] res;
   } bundle_type;
endpackage
`default_nettype wire

@@ hw/rtl/ets_core.sv @@
// Scan core: state update and result bundle for one input byte per cycle while in_valid is high
`default_nettype none
`include "assert_macros.svh"
module ets_core #(
   parameter int POSITION_BITS = ets_pkg::PositionBits
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   input  wire                   in_mode,
   input  wire [7:0]             in_char,
   output ets_pkg::bundle_type   out_bundle
);
   localparam int PB = POSITION_BITS;

   logic [PB-1:0] pos_ff, pos_in, tstart_ff, tstart_in;
   logic [15:0] line_ff, line_in;
   ets_pkg::scan_state_type st_ff, st_in;
   logic [7:0] pend_ff, pend_in;
   logic [30:0] val_ff, val_in;
   ets_pkg::base_type base_ff, base_in;
   logic f_inv_ff, f_adj_ff, f_sep_ff, f_ovf_ff, f_dig_ff;
   logic f_inv_in, f_adj_in, f_sep_in, f_ovf_in, f_dig_in;
   logic [3:0] kw_ff, kw_in;

   // Hold scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; tstart_ff <= '0; line_ff <= '0; st_ff <= ets_pkg::S_IDLE;
         pend_ff <= '0; val_ff <= '0; base_ff <= ets_pkg::B_DEC; kw_ff <= '0;
         f_inv_ff <= 1'b0; f_adj_ff <= 1'b0; f_sep_ff <= 1'b0; f_ovf_ff <= 1'b0;
         f_dig_ff <= 1'b0;
      end else if (in_valid) begin
         pos_ff <= pos_in; tstart_ff <= tstart_in; line_ff <= line_in; st_ff <= st_in;
         pend_ff <= pend_in; val_ff <= val_in; base_ff <= base_in; kw_ff <= kw_in;
         f_inv_ff <= f_inv_in; f_adj_ff <= f_adj_in; f_sep_ff <= f_sep_in;
         f_ovf_ff <= f_ovf_in; f_dig_ff <= f_dig_in;
      end
   end

   function automatic logic is_dig(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic logic is_let(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic logic [15:0] len16(input logic [PB-1:0] a, input logic [PB-1:0] b);
      logic [PB-1:0] d;
      d = b - a;
      return 16'(d);
   endfunction

   // Digit value and radix-scaled accumulation
   logic [4:0]  radix;
   logic [5:0]  dval;
   logic [36:0] prod;
   always_comb begin
      case (base_ff)
         ets_pkg::B_DEC: radix = 5'd10;
         ets_pkg::B_OCT: radix = 5'd8;
         ets_pkg::B_HEX: radix = 5'd16;
         default:        radix = 5'd2;
      endcase
      if (is_dig(in_char)) dval = {2'b0, in_char[3:0]};
      else dval = 6'((in_char | 8'h20) - 8'd87);
      prod = 37'(val_ff) * 37'(radix) + 37'(dval);
   end

   logic [7:0] c;
   logic [PB-1:0] prev, lenpos;
   logic [15:0] line_sat;
   ets_pkg::bundle_type b;
   logic [15:0] ln;

   // Next state and results
   always_comb begin
      logic fresh_go, num_fin, frac_fin, id_fin, op_sgl, dot_tok;
      logic [PB-1:0] fin_len_pos;
      logic [4:0] pk;
      logic [7:0] nx;
      logic [PB-1:0] fs;
      logic bad;
      c = in_char;
      prev = pos_ff - 1'b1;
      line_sat = (line_ff == 16'hFFFF) ? line_ff : line_ff + 16'd1;
      pos_in = pos_ff + 1'b1; tstart_in = tstart_ff; line_in = line_ff; st_in = st_ff;
      pend_in = pend_ff; val_in = val_ff; base_in = base_ff; kw_in = kw_ff;
      f_inv_in = f_inv_ff; f_adj_in = f_adj_ff; f_sep_in = f_sep_ff; f_ovf_in = f_ovf_ff;
      f_dig_in = f_dig_ff;
      b = '0;
      fresh_go = 1'b0; num_fin = 1'b0; frac_fin = 1'b0; id_fin = 1'b0; op_sgl = 1'b0;
      dot_tok = 1'b0; fin_len_pos = pos_ff; pk = '0; nx = '0; bad = 1'b0;
      fs = '0; lenpos = '0;
      ln = line_ff;
      if (in_mode) begin
         // End of input: flush, then END
         case (st_ff)
            ets_pkg::S_OP: op_sgl = 1'b1;
            ets_pkg::S_BLOCK, ets_pkg::S_BLOCK_STAR: begin
               b.res[b.count[1:0]] = '{1'b0, 5'd0, ets_pkg::E_OPEN_COMMENT, 16'(tstart_ff),
                  len16(tstart_ff, pos_ff), ln, 31'd0};
               b.count = b.count + 3'd1;
            end
            ets_pkg::S_ZERO: begin num_fin = 1'b1; base_in = ets_pkg::B_OCT; end
            ets_pkg::S_NUM: num_fin = 1'b1;
            ets_pkg::S_NUM_DOT: begin num_fin = 1'b1; fin_len_pos = prev; dot_tok = 1'b1; end
            ets_pkg::S_FRAC: frac_fin = 1'b1;
            ets_pkg::S_IDENT: id_fin = 1'b1;
            default: ;
         endcase
      end else begin
         if (st_ff == ets_pkg::S_ZERO && c != "x" && c != "X" && c != "b" && c != "B") begin
            base_in = ets_pkg::B_OCT;
         end
         case (st_ff)
            ets_pkg::S_OP: begin
               if (c == "=" && pend_ff == "!") pk = ets_pkg::K_BANG_EQ;
               else if (c == "=" && pend_ff == "=") pk = ets_pkg::K_EQ_EQ;
               else if (c == "=" && pend_ff == "<") pk = ets_pkg::K_LESS_EQ;
               else if (c == "=" && pend_ff == ">") pk = ets_pkg::K_GREATER_EQ;
               else if (c == "&" && pend_ff == "&") pk = ets_pkg::K_LAND;
               else if (c == "|" && pend_ff == "|") pk = ets_pkg::K_LOR;
               if (pk != 5'd0) begin
                  b.res[0] = '{1'b1, pk, ets_pkg::E_NONE, 16'(tstart_ff), 16'd2, ln, 31'd0};
                  b.count = 3'd1;
                  st_in = ets_pkg::S_IDLE;
               end else if (pend_ff == "/" && c == "/") st_in = ets_pkg::S_LINE;
               else if (pend_ff == "/" && c == "*") st_in = ets_pkg::S_BLOCK;
               else begin op_sgl = 1'b1; fresh_go = 1'b1; end
            end
            ets_pkg::S_LINE: if (c == 8'h0A) begin line_in = line_sat; st_in = ets_pkg::S_IDLE; end
            ets_pkg::S_BLOCK: begin
               if (c == "*") st_in = ets_pkg::S_BLOCK_STAR;
               else if (c == 8'h0A) line_in = line_sat;
            end
            ets_pkg::S_BLOCK_STAR: begin
               if (c == "/") st_in = ets_pkg::S_IDLE;
               else if (c != "*") begin
                  if (c == 8'h0A) line_in = line_sat;
                  st_in = ets_pkg::S_BLOCK;
               end
            end
            ets_pkg::S_ZERO, ets_pkg::S_NUM: begin
               if (st_ff == ets_pkg::S_ZERO && (c == "x" || c == "X" || c == "b" || c == "B")) begin
                  base_in = (c == "x" || c == "X") ? ets_pkg::B_HEX : ets_pkg::B_BIN;
                  val_in = '0; f_inv_in = 1'b0; f_adj_in = 1'b0; f_sep_in = 1'b0;
                  f_ovf_in = 1'b0; f_dig_in = 1'b0; st_in = ets_pkg::S_NUM;
               end else if (is_dig(c) || is_let(c) || c == 8'h27) begin
                  st_in = ets_pkg::S_NUM;
                  if (c == 8'h27) begin
                     if (f_sep_ff) f_adj_in = 1'b1;
                     f_sep_in = 1'b1;
                  end else begin
                     f_sep_in = 1'b0;
                     if (!(f_inv_ff || f_ovf_ff)) begin
                        // radix: octal when leaving the zero state
                        if (dval >= ((st_ff == ets_pkg::S_ZERO) ? 6'd8 : {1'b0, radix}))
                           f_inv_in = 1'b1;
                        else begin
                           f_dig_in = 1'b1;
                           if (st_ff == ets_pkg::S_ZERO) val_in = 31'(dval);
                           else if (prod > 37'h7FFFFFFF) f_ovf_in = 1'b1;
                           else val_in = prod[30:0];
                        end
                     end
                  end
               end else if (c == ".") st_in = ets_pkg::S_NUM_DOT;
               else begin num_fin = 1'b1; fresh_go = 1'b1; end
            end
            ets_pkg::S_NUM_DOT: begin
               if (is_dig(c)) st_in = ets_pkg::S_FRAC;
               else begin num_fin = 1'b1; fin_len_pos = prev; dot_tok = 1'b1; fresh_go = 1'b1; end
            end
            ets_pkg::S_FRAC: if (!is_dig(c)) begin frac_fin = 1'b1; fresh_go = 1'b1; end
            ets_pkg::S_IDENT: begin
               if (is_let(c) || is_dig(c) || c == "_") begin
                  case (kw_ff)
                     4'd1: nx = "r"; 4'd2: nx = "u"; 4'd3: nx = "e";
                     4'd5: nx = "a"; 4'd6: nx = "l"; 4'd7: nx = "s"; 4'd8: nx = "e";
                     default: nx = 8'd0;
                  endcase
                  kw_in = (nx != 8'd0 && c == nx) ? kw_ff + 4'd1 : 4'd0;
               end else begin id_fin = 1'b1; fresh_go = 1'b1; end
            end
            default: fresh_go = 1'b1;
         endcase
      end
      lenpos = fin_len_pos;
      // Emit pending operator alone
      if (op_sgl) begin
         case (pend_ff)
            "!": pk = ets_pkg::K_BANG;    "<": pk = ets_pkg::K_LESS;
            ">": pk = ets_pkg::K_GREATER; "&": pk = ets_pkg::K_BAND;
            "|": pk = ets_pkg::K_BOR;     "/": pk = ets_pkg::K_SLASH;
            default: pk = 5'd0;
         endcase
         if (pend_ff == "=")
            b.res[b.count[1:0]] = '{1'b0, 5'd0, ets_pkg::E_UNEXPECTED, 16'(tstart_ff), 16'd1,
               ln, 31'd0};
         else
            b.res[b.count[1:0]] = '{1'b1, pk, ets_pkg::E_NONE, 16'(tstart_ff), 16'd1, ln,
               31'd0};
         b.count = b.count + 3'd1;
      end
      // Close number
      if (num_fin) begin
         bad = f_inv_ff;
         if (f_adj_ff) begin
            b.res[b.count[1:0]] = '{1'b0, 5'd0, ets_pkg::E_ADJ_SEP, 16'(tstart_ff),
               len16(tstart_ff, lenpos), ln, 31'd0};
            b.count = b.count + 3'd1;
         end else if (f_sep_ff) begin
            b.res[b.count[1:0]] = '{1'b0, 5'd0, ets_pkg::E_UNEXPECTED, 16'(tstart_ff),
               len16(tstart_ff, lenpos), ln, 31'd0};
            b.count = b.count + 3'd1;
         end else if (f_ovf_ff || (!f_dig_ff && base_ff == ets_pkg::B_BIN)) begin
            b.res[b.count[1:0]] = '{1'b0, 5'd0, ets_pkg::E_INVALID_NUM, 16'(tstart_ff),
               len16(tstart_ff, lenpos), ln, 31'd0};
            b.count = b.count + 3'd1;
         end else begin
            if (!f_dig_ff) bad = 1'b1;
            b.res[b.count[1:0]] = '{1'b1, ets_pkg::K_NUMBER, ets_pkg::E_NONE, 16'(tstart_ff),
               len16(tstart_ff, lenpos), ln, val_ff};
            b.count = b.count + 3'd1;
            if (bad) begin
               b.res[b.count[1:0]] = '{1'b0, 5'd0, ets_pkg::E_INVALID_NUM, 16'(tstart_ff),
                  len16(tstart_ff, lenpos), ln, 31'd0};
               b.count = b.count + 3'd1;
            end
         end
      end
      if (dot_tok) begin
         b.res[b.count[1:0]] = '{1'b1, ets_pkg::K_DOT, ets_pkg::E_NONE, 16'(prev), 16'd1, ln,
            31'd0};
         b.count = b.count + 3'd1;
      end
      if (frac_fin) begin
         if (f_adj_ff) begin
            b.res[b.count[1:0]] = '{1'b0, 5'd0, ets_pkg::E_ADJ_SEP, 16'(tstart_ff),
               len16(tstart_ff, pos_ff), ln, 31'd0};
            b.count = b.count + 3'd1;
         end
         b.res[b.count[1:0]] = '{1'b0, 5'd0, ets_pkg::E_FRACTION, 16'(tstart_ff),
            len16(tstart_ff, pos_ff), ln, 31'd0};
         b.count = b.count + 3'd1;
      end
      if (id_fin) begin
         if (kw_ff == 4'd4)
            b.res[b.count[1:0]] = '{1'b1, ets_pkg::K_TRUE, ets_pkg::E_NONE, 16'(tstart_ff),
               len16(tstart_ff, pos_ff), ln, 31'd1};
         else
            b.res[b.count[1:0]] = '{1'b1,
               (kw_ff == 4'd9) ? ets_pkg::K_FALSE : ets_pkg::K_IDENT,
               ets_pkg::E_NONE, 16'(tstart_ff), len16(tstart_ff, pos_ff), ln, 31'd0};
         b.count = b.count + 3'd1;
      end
      // Start fresh on the current byte
      if (fresh_go) begin
         fs = pos_ff;
         st_in = ets_pkg::S_IDLE; tstart_in = fs;
         case (c)
            "(", ")", "{", "}", ":", ",", ".", "-", "+", "?", "*", "^": begin
               case (c)
                  "(": pk = 5'd0;  ")": pk = 5'd1;  "{": pk = 5'd2;  "}": pk = 5'd3;
                  ":": pk = 5'd4;  ",": pk = 5'd5;  ".": pk = 5'd6;  "-": pk = 5'd7;
                  "+": pk = 5'd8;  "?": pk = 5'd9;  "*": pk = 5'd10; default: pk = 5'd11;
               endcase
               b.res[b.count[1:0]] = '{1'b1, pk, ets_pkg::E_NONE, 16'(fs), 16'd1, ln, 31'd0};
               b.count = b.count + 3'd1;
            end
            "!", "<", ">", "&", "|", "=", "/": begin pend_in = c; st_in = ets_pkg::S_OP; end
            " ", 8'h0D, 8'h09: ;
            8'h0A: line_in = line_sat;
            default: begin
               if (is_dig(c)) begin
                  val_in = 31'(c[3:0]); f_dig_in = 1'b1; f_inv_in = 1'b0; f_adj_in = 1'b0;
                  f_sep_in = 1'b0; f_ovf_in = 1'b0; base_in = ets_pkg::B_DEC;
                  st_in = (c == "0") ? ets_pkg::S_ZERO : ets_pkg::S_NUM;
               end else if (is_let(c) || c == "_") begin
                  kw_in = (c == "t") ? 4'd1 : (c == "f") ? 4'd5 : 4'd0;
                  st_in = ets_pkg::S_IDENT;
               end else begin
                  b.res[b.count[1:0]] = '{1'b0, 5'd0, ets_pkg::E_UNEXPECTED, 16'(fs), 16'd1,
                     ln, 31'd0};
                  b.count = b.count + 3'd1;
               end
            end
         endcase
      end
      if (in_mode) begin
         b.res[b.count[1:0]] = '{1'b1, ets_pkg::K_END, ets_pkg::E_NONE, 16'(pos_ff), 16'd0,
            ln, 31'd0};
         b.count = b.count + 3'd1;
         pos_in = '0; tstart_in = '0; line_in = '0; st_in = ets_pkg::S_IDLE; pend_in = '0;
         val_in = '0; base_in = ets_pkg::B_DEC; kw_in = '0; f_inv_in = 1'b0; f_adj_in = 1'b0;
         f_sep_in = 1'b0; f_ovf_in = 1'b0; f_dig_in = 1'b0;
      end
      out_bundle = b;
   end

   `ETS_ASSERT_IMP(a_end_emits, clock, reset, in_valid && in_mode, out_bundle.count != 3'd0,
      "end of input without END")
   `ETS_ASSERT_IMP(a_count_max, clock, reset, 1'b1, out_bundle.count <= 3'd4,
      "more than four results")
   `ETS_ASSERT_NXT(a_end_resets, clock, reset, in_valid && in_mode, pos_ff == '0,
      "position not cleared after end")
endmodule
`default_nettype wire

@@ hw/rtl/ets_out.sv @@
// Result queue: holds bundles and sends one result beat at a time
`default_nettype none
module ets_out (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  bundle_valid,
   input  ets_pkg::bundle_type  bundle,
   output logic                 in_ready,
   output logic                 out_valid,
   input  wire                  out_ready,
   output ets_pkg::result_type  out_res,
   output logic                 out_last
);
   // Two bundle slots, ping-pong
   ets_pkg::bundle_type slot_ff [2];
   logic [1:0] full_ff, full_in;
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] idx_ff, idx_in;
   logic take, pop, push;

   always_comb begin
      in_ready = !full_ff[wr_ff];
      push = bundle_valid && in_ready && (bundle.count != 3'd0);
      out_valid = full_ff[rd_ff];
      out_res = slot_ff[rd_ff].res[idx_ff];
      out_last = (3'(idx_ff) + 3'd1) == slot_ff[rd_ff].count;
      take = out_valid && out_ready;
      pop = take && out_last;
      full_in = full_ff; wr_in = wr_ff; rd_in = rd_ff; idx_in = idx_ff;
      if (take) idx_in = pop ? 2'd0 : idx_ff + 2'd1;
      if (pop) begin full_in[rd_ff] = 1'b0; rd_in = !rd_ff; end
      if (push) begin full_in[wr_ff] = 1'b1; wr_in = !wr_ff; end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0; wr_ff <= 1'b0; rd_ff <= 1'b0; idx_ff <= '0;
      end else begin
         full_ff <= full_in; wr_ff <= wr_in; rd_ff <= rd_in; idx_ff <= idx_in;
      end
   end

   // Capture bundle payload
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= bundle;
   end
endmodule
`default_nettype wire

@@ hw/rtl/expression_token_scanner.sv @@
// Top level of the expression token scanner
`default_nettype none
// Streaming lexer: one source byte (or end marker) per beat, accepted every cycle while
// the two-bundle result queue has room. Each byte is resolved by combinational scan logic
// and yields up to four result beats, which drain one per cycle while rsp_tready is high.
module expression_token_scanner #(
   parameter int POSITION_BITS = ets_pkg::PositionBits
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] char_byte
   input  wire         req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [87:0] rsp_tdata,   // [15:0] lexeme_start [31:16] lexeme_length
                                    // [47:32] line_number [78:48] literal_value
   output logic [8:0]  rsp_tuser,   // [0] is_token [5:1] token_kind [8:6] error_code
   output logic        rsp_tlast    // last_result
);
   ets_pkg::bundle_type bundle;
   ets_pkg::result_type res;
   logic acc;

   assign acc = req_tvalid && req_tready;

   ets_core #(.POSITION_BITS(POSITION_BITS)) u_core (
      .clock(clock), .reset(reset), .in_valid(acc), .in_mode(req_tuser),
      .in_char(req_tdata), .out_bundle(bundle)
   );

   ets_out u_out (
      .clock(clock), .reset(reset), .bundle_valid(req_tvalid), .bundle(bundle),
      .in_ready(req_tready), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_res(res), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {9'd0, res.literal_value, res.line_number, res.lexeme_length,
                       res.lexeme_start};
   assign rsp_tuser = {res.error_code, res.token_kind, res.is_token};
endmodule
`default_nettype wire
